/* rtl/eight_ary_max_tree_argmax_assert.svh */
// Assertion macros for the checker file of the max tree block.
// No dependencies; include by bare file name.
`ifndef EIGHT_ARY_MAX_TREE_ARGMAX_ASSERT_SVH
`define EIGHT_ARY_MAX_TREE_ARGMAX_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define EAMT_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("eamt: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define EAMT_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("eamt: next-cycle check failed");

`endif

/* rtl/eamt_pkg.sv */
// Shared constants, types and tree-shape helpers for the 8-ary max tree.
// No dependencies; imported by every module of the block but eamt_ram and eamt_checker.
package eamt_pkg;

    localparam int unsigned MAX_LEAVES = 4096;
    localparam int unsigned FANOUT     = 8;
    localparam int unsigned FAN_W      = $clog2(FANOUT);
    localparam int unsigned VAL_W      = 31;
    localparam int unsigned LEAF_W     = 12;
    localparam int unsigned CFG_W      = 13;
    localparam int unsigned TOP_W      = 12;

    // number of stored levels (leaf rows up to the single row below the root)
    function automatic int unsigned tree_levels();
        int unsigned n;
        int unsigned cnt;
        n   = MAX_LEAVES;
        cnt = 0;
        while (n > 1)
        begin
            n   = (n + FANOUT - 1) / FANOUT;
            cnt = cnt + 1;
        end
        return cnt;
    endfunction

    // first memory row of a level; rows of level l hold the nodes of level l
    function automatic int unsigned level_base(int unsigned l);
        int unsigned base;
        int unsigned n;
        base = 0;
        n    = MAX_LEAVES;
        for (int unsigned j = 0; j < l; j++)
        begin
            n    = (n + FANOUT - 1) / FANOUT;
            base = base + n;
        end
        return base;
    endfunction

    localparam int unsigned TREE_LEVELS = tree_levels();
    localparam int unsigned ROW_COUNT   = level_base(TREE_LEVELS);
    localparam int unsigned ROW_AW      = $clog2(ROW_COUNT);
    localparam int unsigned LVL_W       = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

    typedef logic [VAL_W-1:0]              val_t;
    typedef logic [LEAF_W-1:0]             leaf_idx_t;
    typedef logic [CFG_W-1:0]              cfg_t;
    typedef logic [FAN_W-1:0]              lane_t;
    typedef logic [FANOUT-1:0][VAL_W-1:0]  row_t;
    typedef logic [ROW_AW-1:0]             row_addr_t;
    typedef logic [LVL_W-1:0]              lvl_t;

    typedef struct packed {
        leaf_idx_t leaf_index;
        val_t      leaf_value;
    } cmd_t;

    typedef struct packed {
        logic [TOP_W-1:0] top_index;
        logic             index_error;
    } result_t;

    typedef struct packed {
        logic      wr_en;
        row_addr_t wr_addr;
        logic      rd_en;
        row_addr_t rd_addr;
    } mem_req_t;

    typedef struct packed {
        row_t  new_row;
        val_t  row_max;
        lane_t hit_lane;
    } node_out_t;

    // row holding the level-l node on the path of a leaf
    function automatic row_addr_t up_addr(int unsigned l, leaf_idx_t idx);
        row_addr_t base;
        base = ROW_AW'(level_base(l));
        return base + ROW_AW'(idx >> (FAN_W * (l + 1)));
    endfunction

endpackage

/* rtl/eight_ary_max_tree_argmax.sv */
// Top level of the 8-ary max tree with leftmost argmax.
// Depends on eamt_pkg, eamt_ctrl, eamt_node_unit and eamt_ram.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------
//  command  | start / busy          | cmd    (leaf_index, leaf_value)
//  result   | done (one-cycle)      | result (top_index, index_error)
//  config   | cfg_valid / cfg_ready | cfg_data (leaves_in_use)
//
// An accepted item makes one row access of the tree memory per level on the way
// up, then one per level on the way down; an item whose index is rejected skips
// the way up. done pulses in the cycle busy drops; a new item may start then.
// After reset and after every register write a clearing sweep of 585 rows
// runs with busy high. Results cannot be stalled.
module eight_ary_max_tree_argmax
    import eamt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  cfg_t    cfg_data
);

    mem_req_t mem_req;
    row_t     wr_data;
    row_t     rd_data;

    eamt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result),
        .mem_req   (mem_req),
        .wr_data   (wr_data),
        .rd_data   (rd_data)
    );

    // leaf rows and inner rows share one memory, one row of FANOUT nodes a word
    eamt_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (ROW_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* rtl/eamt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module eamt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/eamt_node_unit.sv */
// Row operations of the max tree: lane overwrite, maximum over the row,
// first lane matching a key. Depends on eamt_pkg.
module eamt_node_unit
    import eamt_pkg::*;
(
    input  row_t      row,
    input  lane_t     lane,
    input  val_t      value,
    input  val_t      key,
    output node_out_t res
);

    always_comb
    begin
        row_t  mod_row;
        val_t  heap [1:2*FANOUT-1];
        lane_t hit;

        mod_row       = row;
        mod_row[lane] = value;

        // balanced compare tree, leaves at FANOUT..2*FANOUT-1
        for (int i = 0; i < int'(FANOUT); i++)
        begin
            heap[int'(FANOUT) + i] = mod_row[i];
        end
        for (int k = int'(FANOUT) - 1; k >= 1; k--)
        begin
            heap[k] = (heap[2*k] >= heap[2*k+1]) ? heap[2*k] : heap[2*k+1];
        end

        // leftmost lane equal to the key; lane 0 if none
        hit = '0;
        for (int i = int'(FANOUT) - 1; i >= 0; i--)
        begin
            if (row[i] == key)
            begin
                hit = lane_t'(i);
            end
        end

        res.new_row  = mod_row;
        res.row_max  = heap[1];
        res.hit_lane = hit;
    end

endmodule

/* rtl/eamt_ctrl.sv */
// Sequencer of the max tree: clearing sweep, path update up the levels,
// leftmost-argmax walk down. Depends on eamt_pkg and eamt_node_unit.
module eamt_ctrl
    import eamt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     cmd,
    output logic     busy,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_t     cfg_data,
    output logic     done,
    output result_t  result,
    output mem_req_t mem_req,
    output row_t     wr_data,
    input  row_t     rd_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UP,
        ST_DREAD,
        ST_DOWN
    } state_t;

    state_t    state_reg,  state_next;
    lvl_t      lvl_reg,    lvl_next;
    row_addr_t clr_reg,    clr_next;
    leaf_idx_t idx_reg,    idx_next;
    val_t      val_reg,    val_next;
    val_t      carry_reg,  carry_next;
    val_t      root_reg,   root_next;
    leaf_idx_t walk_reg,   walk_next;
    logic      bad_reg,    bad_next;
    cfg_t      leaves_reg, leaves_next;
    logic      done_reg,   done_next;
    result_t   result_reg, result_next;

    lane_t     nu_lane;
    val_t      nu_value;
    node_out_t nu_res;
    logic      cmd_bad;
    leaf_idx_t walk_step;

    eamt_node_unit u_node (
        .row   (rd_data),
        .lane  (nu_lane),
        .value (nu_value),
        .key   (root_reg),
        .res   (nu_res)
    );

    assign cmd_bad = (CFG_W'(cmd.leaf_index) >= leaves_reg)
                  || (CFG_W'(cmd.leaf_index) >= CFG_W'(MAX_LEAVES));

    assign walk_step = {walk_reg[LEAF_W-FAN_W-1:0], nu_res.hit_lane};

    assign cfg_ready = (state_reg == ST_CLEAR) || ((state_reg == ST_IDLE) && !start);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        nu_lane  = '0;
        for (int unsigned l = 0; l < TREE_LEVELS; l++)
        begin
            if (lvl_reg == LVL_W'(l))
            begin
                nu_lane = idx_reg[FAN_W*l +: FAN_W];
            end
        end
        nu_value = (lvl_reg == '0) ? val_reg : carry_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        carry_next  = carry_reg;
        root_next   = root_reg;
        walk_next   = walk_reg;
        bad_next    = bad_reg;
        leaves_next = leaves_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_req     = '0;
        wr_data     = nu_res.new_row;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                wr_data         = '0;
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == ROW_AW'(ROW_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next        = cmd.leaf_index;
                    val_next        = cmd.leaf_value;
                    bad_next        = cmd_bad;
                    lvl_next        = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = up_addr(0, cmd.leaf_index);
                    state_next      = cmd_bad ? ST_DREAD : ST_UP;
                end
            end
            ST_UP:
            begin
                // write back the row of this level, fetch the row one level up unless at the top
                mem_req.wr_en = 1'b1;
                for (int unsigned l = 0; l < TREE_LEVELS; l++)
                begin
                    if (lvl_reg == LVL_W'(l))
                    begin
                        mem_req.wr_addr = up_addr(l, idx_reg);
                        if (l + 1 < TREE_LEVELS)
                        begin
                            mem_req.rd_addr = up_addr(l + 1, idx_reg);
                        end
                    end
                end
                carry_next = nu_res.row_max;
                if (lvl_reg == LVL_W'(TREE_LEVELS - 1))
                begin
                    root_next  = nu_res.row_max;
                    state_next = ST_DREAD;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    lvl_next      = lvl_reg + 1'b1;
                end
            end
            ST_DREAD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ROW_AW'(level_base(TREE_LEVELS - 1));
                walk_next       = '0;
                lvl_next        = LVL_W'(TREE_LEVELS - 1);
                state_next      = ST_DOWN;
            end
            ST_DOWN:
            begin
                // take the first child equal to the root, then descend; at level 0 report the leaf
                walk_next = walk_step;
                if (lvl_reg == '0)
                begin
                    result_next.top_index   = TOP_W'(walk_step);
                    result_next.index_error = bad_reg;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    for (int unsigned l = 1; l < TREE_LEVELS; l++)
                    begin
                        if (lvl_reg == LVL_W'(l))
                        begin
                            mem_req.rd_addr = ROW_AW'(level_base(l - 1)) + ROW_AW'(walk_step);
                        end
                    end
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a register write saturates and restarts the clearing sweep
        if (cfg_valid && cfg_ready)
        begin
            leaves_next = (cfg_data > CFG_W'(MAX_LEAVES)) ? CFG_W'(MAX_LEAVES) : cfg_data;
            clr_next    = '0;
            root_next   = '0;
            state_next  = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            lvl_reg    <= '0;
            clr_reg    <= '0;
            idx_reg    <= '0;
            val_reg    <= '0;
            carry_reg  <= '0;
            root_reg   <= '0;
            walk_reg   <= '0;
            bad_reg    <= 1'b0;
            leaves_reg <= CFG_W'(MAX_LEAVES);
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lvl_reg    <= lvl_next;
            clr_reg    <= clr_next;
            idx_reg    <= idx_next;
            val_reg    <= val_next;
            carry_reg  <= carry_next;
            root_reg   <= root_next;
            walk_reg   <= walk_next;
            bad_reg    <= bad_next;
            leaves_reg <= leaves_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

endmodule

/* rtl/eamt_checker.sv */
// Port-level checks for the max tree block, bound to the top level.
// Depends on eight_ary_max_tree_argmax_assert.svh.
`include "eight_ary_max_tree_argmax_assert.svh"

module eamt_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);

    `EAMT_ASSERT_IMP(a_done_when_idle, clk, rst_n, done, !busy)
    `EAMT_ASSERT_NXT(a_accept_sets_busy, clk, rst_n, start && !busy, busy && !done)
    `EAMT_ASSERT_NXT(a_single_strobe, clk, rst_n, done, !done)
    `EAMT_ASSERT_NXT(a_cfg_clears, clk, rst_n, cfg_valid && cfg_ready, busy && !done)

endmodule

bind eight_ary_max_tree_argmax eamt_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

/* bench/tb_eight_ary_max_tree_argmax.sv */
`timescale 1ns / 1ps
// Testbench for the 8-ary max tree with leftmost argmax.
// Depends on eamt_pkg and eight_ary_max_tree_argmax; keeps its own copy of the
// leaf table and checks every reported top index and error flag in order.
module tb_eight_ary_max_tree_argmax;
    import eamt_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_GAP        = 60;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam val_t        VAL_TOP        = '1;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    start     = 1'b0;
    logic    busy;
    cmd_t    cmd       = '0;
    logic    done;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    cfg_t    cfg_data  = '0;

    val_t        leaf_mirror [MAX_LEAVES];
    int unsigned leaves_limit;
    result_t     expected_tops [$];
    result_t     want;
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned idle_pct     = 0;

    always #5 clk = ~clk;

    eight_ary_max_tree_argmax u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // leftmost leaf holding the largest value; all-equal gives leaf 0
    function automatic logic [TOP_W-1:0] leftmost_max_leaf();
        int unsigned best_idx;
        val_t        best_val;
        best_idx = 0;
        best_val = '0;
        for (int unsigned i = 0; i < MAX_LEAVES; i++)
        begin
            if (leaf_mirror[i] > best_val)
            begin
                best_val = leaf_mirror[i];
                best_idx = i;
            end
        end
        return TOP_W'(best_idx);
    endfunction

    function automatic result_t apply_leaf_write(input cmd_t c);
        result_t r;
        r.index_error = (c.leaf_index >= leaves_limit);
        if (!r.index_error)
            leaf_mirror[c.leaf_index] = c.leaf_value;
        r.top_index = leftmost_max_leaf();
        return r;
    endfunction

    function automatic cmd_t random_leaf_write();
        cmd_t        c;
        int unsigned pick;
        int unsigned hot;
        pick = $urandom_range(99);
        if (leaves_limit == 0 || pick < 10)
            c.leaf_index = LEAF_W'($urandom_range(MAX_LEAVES - 1));
        else if (pick < 40)
        begin
            // a few hot leaves so maxima get overwritten and ties form
            hot = (leaves_limit < 16) ? leaves_limit : 16;
            c.leaf_index = LEAF_W'($urandom_range(hot - 1));
        end
        else if (pick < 48)
            c.leaf_index = LEAF_W'(leaves_limit - 1 + $urandom_range(1));
        else
            c.leaf_index = LEAF_W'($urandom_range(leaves_limit - 1));
        pick = $urandom_range(99);
        if (pick < 20)
            c.leaf_value = '0;
        else if (pick < 55)
            c.leaf_value = VAL_W'($urandom_range(7));
        else if (pick < 65)
            c.leaf_value = VAL_TOP - VAL_W'($urandom_range(1));
        else
            c.leaf_value = VAL_W'($urandom);
        return c;
    endfunction

    // entered and left at a falling edge; start is redrawn each cycle and
    // forced high once gap (idle draws while the block was free) hits MAX_GAP
    task automatic send_item(input cmd_t c);
        int unsigned gap;
        logic        taken;
        gap   = 0;
        taken = 1'b0;
        cmd   = c;
        while (!taken)
        begin
            start = (gap >= MAX_GAP) || ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            taken = start && !busy;
            if (!taken)
            begin
                if (!busy)
                    gap++;
                @(negedge clk);
            end
        end
        expected_tops = {expected_tops, apply_leaf_write(c)};
        @(negedge clk);
    endtask

    task automatic send_leaf(input int unsigned idx, input val_t v);
        cmd_t c;
        c.leaf_index = LEAF_W'(idx);
        c.leaf_value = v;
        send_item(c);
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (expected_tops.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_leaf_count(input cfg_t v);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        leaves_limit = (v > MAX_LEAVES) ? MAX_LEAVES : v;
        foreach (leaf_mirror[i])
            leaf_mirror[i] = '0;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // extreme values and positions, ties, demoting the current maximum
    task automatic test_leaf_extremes();
        idle_pct = 0;
        send_leaf(0, '0);
        send_leaf(4095, VAL_TOP);
        send_leaf(0, VAL_TOP);
        send_leaf(0, 31'd1);
        send_leaf(2048, VAL_TOP);
        send_leaf(4095, '0);
        send_leaf(2048, '0);
        send_leaf(0, '0);
        send_leaf(12'hAAA, 31'h2AAA_AAAA);
        send_leaf(12'h555, 31'h5555_5555);
    endtask

    // leaf count register: clearing, rejection, zero, saturation
    task automatic test_leaf_count();
        write_leaf_count(13'd100);
        send_leaf(99, 31'd5);
        send_leaf(100, 31'd9);
        send_leaf(4095, VAL_TOP);
        write_leaf_count(13'd0);
        send_leaf(0, 31'd3);
        send_leaf(4095, VAL_TOP);
        write_leaf_count(13'h1FFF);
        send_leaf(4095, 31'd3);
        send_leaf(0, 31'd3);
        write_leaf_count(13'd1);
        send_leaf(0, 31'd7);
        send_leaf(1, VAL_TOP);
        write_leaf_count(13'd4096);
        send_leaf(4095, 31'd1);
    endtask

    task automatic run_phase(input cfg_t lc, input int unsigned n, input int unsigned pct);
        write_leaf_count(lc);
        idle_pct = pct;
        repeat (n) send_item(random_leaf_write());
    endtask

    task automatic test_random_mix();
        run_phase(13'd4096, 400, 0);
        run_phase(13'd4096, 300, 70);
        run_phase(13'd37, 250, 19);
        run_phase(13'h1FFF, 250, 0);
        run_phase(13'd1, 120, 70);
        run_phase(cfg_t'($urandom_range(1, MAX_LEAVES)), 200, 19);
        run_phase(13'd512, 150, 0);
        run_phase(13'd4095, 100, 70);
    endtask

    // sender holds off until every outstanding result is back
    task automatic test_drain_pause();
        write_leaf_count(13'd64);
        idle_pct = 0;
        repeat (8)
        begin
            repeat (12) send_item(random_leaf_write());
            wait_idle();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_tops.size() == 0)
            begin
                $display("%0t: unexpected result: top_index %0d index_error %0b",
                         $time, result.top_index, result.index_error);
                error_count++;
            end
            else
            begin
                want = expected_tops.pop_front();
                if (result.top_index !== want.top_index)
                begin
                    $display("%0t: top_index expected %0d actual %0d",
                             $time, want.top_index, result.top_index);
                    error_count++;
                end
                if (result.index_error !== want.index_error)
                begin
                    $display("%0t: index_error expected %0b actual %0b",
                             $time, want.index_error, result.index_error);
                    error_count++;
                end
            end
        end
    end

    // clearing sweep after reset and each register write counts as quiet time
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_eight_ary_max_tree_argmax: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        leaves_limit = MAX_LEAVES;
        foreach (leaf_mirror[i])
            leaf_mirror[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_leaf_extremes();
        test_leaf_count();
        test_random_mix();
        test_drain_pause();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_eight_ary_max_tree_argmax: done, clean");
        else
            $display("tb_eight_ary_max_tree_argmax: done, errors");
        $finish;
    end

endmodule
